// ===== hdl/assert_macros.svh =====
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/c2dvs_pkg.sv =====
// shared types, constants and helpers for the streaming 2d convolution core
package c2dvs_pkg;

    // default values of the top level parameters
    localparam int DEF_MAX_KERNEL = 5;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 8;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int TAPIDX_W = 5;
    localparam int POS_W    = 6;
    localparam int KSIZE_W  = 3;
    localparam int DIM_W    = 7;
    localparam int ROW_LIMIT = 64;

    // apb port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes
    localparam logic [1:0] REG_KERNEL_SIZE = 2'd0;
    localparam logic [1:0] REG_IMAGE_ROWS  = 2'd1;
    localparam logic [1:0] REG_IMAGE_COLS  = 2'd2;
    localparam logic [1:0] REG_BIAS        = 2'd3;

    // register reset values
    localparam logic [KSIZE_W-1:0]         RST_KERNEL_SIZE = 3'd5;
    localparam logic [DIM_W-1:0]           RST_IMAGE_ROWS  = 7'd28;
    localparam logic [DIM_W-1:0]           RST_IMAGE_COLS  = 7'd28;
    localparam logic signed [SAMPLE_W-1:0] RST_BIAS        = 16'sd0;

    // input command codes
    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_PIXEL  = 1'b1;

    // input transaction payload
    typedef struct packed {
        logic                       cmd;
        logic [TAPIDX_W-1:0]        tap_index;
        logic signed [SAMPLE_W-1:0] sample;
    } c2dvs_in_t;

    // result transaction payload
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] conv_value;
        logic [POS_W-1:0]           out_row;
        logic [POS_W-1:0]           out_col;
        logic                       frame_last;
    } c2dvs_out_t;

    // window cell control
    typedef struct packed {
        logic shift_en;
        logic load_new;
    } c2dvs_cell_ctl_t;

    // depth of the registered adder tree for n leaves
    function automatic int tree_levels(int n);
        return (n < 2) ? 1 : $clog2(n);
    endfunction

endpackage

// ===== hdl/c2dvs_ram.sv =====
// generic single write port ram with registered read, old data on collision
module c2dvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/c2dvs_cell.sv =====
// window cell: one pixel of the sliding window, its tap weight and the product
module c2dvs_cell #(
    parameter int DATA_WIDTH = c2dvs_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = c2dvs_pkg::DEF_FRAC_BITS
) (
    input  logic                                   aclk,
    input  c2dvs_pkg::c2dvs_cell_ctl_t             ctl,
    input  logic signed [c2dvs_pkg::SAMPLE_W-1:0]  new_val,
    input  logic signed [c2dvs_pkg::SAMPLE_W-1:0]  nb_val,
    input  logic signed [c2dvs_pkg::SAMPLE_W-1:0]  weight_in,
    output logic signed [c2dvs_pkg::SAMPLE_W-1:0]  win_val,
    output logic [DATA_WIDTH-1:0]                  prod
);
    import c2dvs_pkg::*;

    logic signed [SAMPLE_W-1:0]   win_reg;
    logic signed [SAMPLE_W-1:0]   weight_reg;
    logic [DATA_WIDTH-1:0]        prod_reg;
    logic signed [2*SAMPLE_W-1:0] mul;
    logic signed [2*SAMPLE_W-1:0] mul_shr;

    // window pixel: take the neighbor or the new column value
    always_ff @(posedge aclk) begin
        if (ctl.shift_en) begin
            win_reg <= ctl.load_new ? new_val : nb_val;
        end
    end

    // weight follows the tap store every cycle
    always_ff @(posedge aclk) begin
        weight_reg <= weight_in;
    end

    // fixed point product, floor shift, wraps at the data width
    assign mul     = weight_reg * win_reg;
    assign mul_shr = mul >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        prod_reg <= DATA_WIDTH'(mul_shr);
    end

    assign win_val = win_reg;
    assign prod    = prod_reg;

endmodule

// ===== hdl/c2dvs_sum_tree.sv =====
// registered binary adder tree, padded to a power of two with zero leaves
module c2dvs_sum_tree #(
    parameter int N     = 25,
    parameter int WIDTH = c2dvs_pkg::DEF_DATA_WIDTH
) (
    input  logic                      aclk,
    input  logic [N-1:0][WIDTH-1:0]   leaves,
    output logic [WIDTH-1:0]          root
);
    import c2dvs_pkg::*;

    localparam int LEVELS = tree_levels(N);
    localparam int TREE_N = 1 << LEVELS;

    // heap order: node i adds nodes 2i and 2i+1, leaves sit past TREE_N-1
    logic [WIDTH-1:0] node_reg [1:TREE_N-1];

    for (genvar i = 1; i < TREE_N; i++) begin : g_node
        logic [WIDTH-1:0] lhs;
        logic [WIDTH-1:0] rhs;

        if (2 * i >= TREE_N) begin : g_edge
            // children are leaves
            if (2 * i - TREE_N < N) begin : g_lhs
                assign lhs = leaves[2 * i - TREE_N];
            end else begin : g_lhs_pad
                assign lhs = '0;
            end
            if (2 * i + 1 - TREE_N < N) begin : g_rhs
                assign rhs = leaves[2 * i + 1 - TREE_N];
            end else begin : g_rhs_pad
                assign rhs = '0;
            end
        end else begin : g_inner
            assign lhs = node_reg[2 * i];
            assign rhs = node_reg[2 * i + 1];
        end

        always_ff @(posedge aclk) begin
            node_reg[i] <= lhs + rhs;
        end
    end

    assign root = node_reg[1];

endmodule

// ===== hdl/conv2d_valid_stream_core.sv =====
// top level of the streaming valid 2d convolution core
//
//  channel   | direction | handshake       | payload
//  ----------+-----------+-----------------+----------------------------------
//  s_        | in        | s_valid/s_ready | cmd, tap_index, sample
//  m_        | out       | m_valid/m_ready | conv_value, out_row, out_col, last
//  apb       | in/out    | psel/penable    | kernel_size, rows, cols, bias
//
// one input transaction per cycle while s_ready is high, weights and pixels
// alike; a pixel whose window is complete gives its result after the line
// ram read, window shift, products, adder tree, bias.
// reset clears the counters, the registers and the result queue; the line
// rams, window and taps are not cleared. results wait in a queue of
// tree depth + 5 entries; s_ready drops only while that many results are
// outstanding.
module conv2d_valid_stream_core #(
    parameter int MAX_KERNEL = c2dvs_pkg::DEF_MAX_KERNEL,
    parameter int MAX_COLS   = c2dvs_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = c2dvs_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = c2dvs_pkg::DEF_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_valid,
    output logic                            s_ready,
    input  c2dvs_pkg::c2dvs_in_t            s_data,
    // result stream
    output logic                            m_valid,
    input  logic                            m_ready,
    output c2dvs_pkg::c2dvs_out_t           m_data,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [c2dvs_pkg::APB_AW-1:0]    paddr,
    input  logic [c2dvs_pkg::APB_DW-1:0]    pwdata,
    output logic [c2dvs_pkg::APB_DW-1:0]    prdata,
    output logic                            pready
);
    import c2dvs_pkg::*;

    `include "assert_macros.svh"

    localparam int NUM_TAPS   = MAX_KERNEL * MAX_KERNEL;
    localparam int NUM_LINES  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int COL_LIMIT  = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam int COL_W      = $clog2(COL_LIMIT);
    localparam int LN_W       = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int TAP_W      = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int LEVELS     = tree_levels(NUM_TAPS);
    localparam int FIFO_DEPTH = LEVELS + 5;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

    // result tag travelling beside the arithmetic
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             last;
    } meta_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [KSIZE_W-1:0]         kernel_size_reg;
    logic [DIM_W-1:0]           image_rows_reg;
    logic [DIM_W-1:0]           image_cols_reg;
    logic signed [SAMPLE_W-1:0] bias_reg;
    logic                       cfg_wr;
    logic [1:0]                 cfg_idx;
    logic                       cfg_geom_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_geom_wr = cfg_wr && ((cfg_idx == REG_KERNEL_SIZE) ||
                                    (cfg_idx == REG_IMAGE_ROWS) ||
                                    (cfg_idx == REG_IMAGE_COLS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_size_reg <= RST_KERNEL_SIZE;
            image_rows_reg  <= RST_IMAGE_ROWS;
            image_cols_reg  <= RST_IMAGE_COLS;
            bias_reg        <= RST_BIAS;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KERNEL_SIZE: kernel_size_reg <= pwdata[KSIZE_W-1:0];
                REG_IMAGE_ROWS:  image_rows_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_COLS:  image_cols_reg  <= pwdata[DIM_W-1:0];
                REG_BIAS:        bias_reg        <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (cfg_idx)
            REG_KERNEL_SIZE: prdata = APB_DW'(kernel_size_reg);
            REG_IMAGE_ROWS:  prdata = APB_DW'(image_rows_reg);
            REG_IMAGE_COLS:  prdata = APB_DW'(image_cols_reg);
            REG_BIAS:        prdata = APB_DW'(unsigned'(bias_reg));
            default:         prdata = '0;
        endcase
    end

    // effective geometry with out of range values clamped
    logic [KSIZE_W-1:0] k_eff;
    logic [KSIZE_W-1:0] km1;
    logic [DIM_W-1:0]   rows_eff;
    logic [DIM_W-1:0]   cols_eff;

    always_comb begin
        if (kernel_size_reg == '0) begin
            k_eff = KSIZE_W'(1);
        end else if (kernel_size_reg > KSIZE_W'(MAX_KERNEL)) begin
            k_eff = KSIZE_W'(MAX_KERNEL);
        end else begin
            k_eff = kernel_size_reg;
        end

        if (image_rows_reg == '0) begin
            rows_eff = DIM_W'(1);
        end else if (image_rows_reg > DIM_W'(ROW_LIMIT)) begin
            rows_eff = DIM_W'(ROW_LIMIT);
        end else begin
            rows_eff = image_rows_reg;
        end

        if (image_cols_reg == '0) begin
            cols_eff = DIM_W'(1);
        end else if (image_cols_reg > DIM_W'(COL_LIMIT)) begin
            cols_eff = DIM_W'(COL_LIMIT);
        end else begin
            cols_eff = image_cols_reg;
        end
    end

    assign km1 = k_eff - KSIZE_W'(1);

    // ---------------------------------------------------------------
    // input handshake and credit
    // ---------------------------------------------------------------
    logic [FC_W-1:0] outstanding_reg;
    logic [FC_W-1:0] outstanding_next;
    logic            in_acc;
    logic            pix_acc;
    logic            wt_acc;
    logic            pop;
    logic            push;

    assign s_ready = outstanding_reg < FC_W'(FIFO_DEPTH);
    assign in_acc  = s_valid && s_ready;
    assign pix_acc = in_acc && (s_data.cmd == CMD_PIXEL);
    assign wt_acc  = in_acc && (s_data.cmd == CMD_WEIGHT);

    // ---------------------------------------------------------------
    // kernel tap store
    // ---------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] taps_reg [NUM_TAPS];

    always_ff @(posedge aclk) begin
        if (wt_acc && (int'(s_data.tap_index) < NUM_TAPS)) begin
            taps_reg[TAP_W'(s_data.tap_index)] <= s_data.sample;
        end
    end

    // ---------------------------------------------------------------
    // raster counters
    // ---------------------------------------------------------------
    logic [POS_W-1:0] pix_row_reg;
    logic [POS_W-1:0] pix_row_next;
    logic [COL_W-1:0] pix_col_reg;
    logic [COL_W-1:0] pix_col_next;
    logic [LN_W-1:0]  wr_line_reg;
    logic [LN_W-1:0]  wr_line_next;
    logic             col_wrap;
    logic             row_wrap;
    logic             pix_emit;
    logic             pix_last;

    assign col_wrap = (DIM_W'(pix_col_reg) + DIM_W'(1)) >= cols_eff;
    assign row_wrap = (DIM_W'(pix_row_reg) + DIM_W'(1)) >= rows_eff;
    assign pix_emit = (DIM_W'(pix_row_reg) >= DIM_W'(km1)) &&
                      (DIM_W'(pix_col_reg) >= DIM_W'(km1));
    assign pix_last = ((DIM_W'(pix_row_reg) + DIM_W'(1)) == rows_eff) &&
                      ((DIM_W'(pix_col_reg) + DIM_W'(1)) == cols_eff);

    always_comb begin
        pix_row_next = pix_row_reg;
        pix_col_next = pix_col_reg;
        wr_line_next = wr_line_reg;
        if (cfg_geom_wr) begin
            pix_row_next = '0;
            pix_col_next = '0;
            wr_line_next = '0;
        end else if (pix_acc) begin
            if (col_wrap) begin
                pix_col_next = '0;
                if (row_wrap) begin
                    pix_row_next = '0;
                    wr_line_next = '0;
                end else begin
                    pix_row_next = pix_row_reg + POS_W'(1);
                    wr_line_next = (wr_line_reg == LN_W'(NUM_LINES - 1)) ?
                                   '0 : wr_line_reg + LN_W'(1);
                end
            end else begin
                pix_col_next = pix_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_row_reg <= '0;
            pix_col_reg <= '0;
            wr_line_reg <= '0;
        end else begin
            pix_row_reg <= pix_row_next;
            pix_col_reg <= pix_col_next;
            wr_line_reg <= wr_line_next;
        end
    end

    // ---------------------------------------------------------------
    // line buffers: one ram per stored row, all read at the current column
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0] ram_rdata [NUM_LINES];

    for (genvar ln = 0; ln < NUM_LINES; ln++) begin : g_line
        c2dvs_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (COL_LIMIT)
        ) u_line_ram (
            .aclk  (aclk),
            .we    (pix_acc && (wr_line_reg == LN_W'(ln))),
            .waddr (pix_col_reg),
            .wdata (s_data.sample),
            .raddr (pix_col_reg),
            .rdata (ram_rdata[ln])
        );
    end

    // ---------------------------------------------------------------
    // pixel stage: holds the accepted pixel while the line rams answer
    // ---------------------------------------------------------------
    logic                       a_valid_reg;
    logic signed [SAMPLE_W-1:0] a_sample_reg;
    logic [POS_W-1:0]           a_row_reg;
    logic [COL_W-1:0]           a_col_reg;
    logic [LN_W-1:0]            a_wrline_reg;
    logic                       a_emit_reg;
    logic                       a_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= pix_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_acc) begin
            a_sample_reg <= s_data.sample;
            a_row_reg    <= pix_row_reg;
            a_col_reg    <= pix_col_reg;
            a_wrline_reg <= wr_line_reg;
            a_emit_reg   <= pix_emit;
            a_last_reg   <= pix_last;
        end
    end

    // new column of the window, one value per window row
    logic signed [SAMPLE_W-1:0] row_val [MAX_KERNEL];

    always_comb begin
        logic [4:0] src_full;
        logic [4:0] src;
        for (int ki = 0; ki < MAX_KERNEL; ki++) begin
            src_full = 5'(a_wrline_reg) + 5'(NUM_LINES) + 5'(ki) - 5'(km1);
            src      = (src_full >= 5'(NUM_LINES)) ? src_full - 5'(NUM_LINES) : src_full;
            if (KSIZE_W'(ki) == km1) begin
                row_val[ki] = a_sample_reg;
            end else if ((KSIZE_W'(ki) < km1) &&
                         ((DIM_W'(a_row_reg) + DIM_W'(ki)) >= DIM_W'(km1))) begin
                row_val[ki] = signed'(ram_rdata[src[LN_W-1:0]]);
            end else begin
                row_val[ki] = '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // window: rows of cells shifting toward column zero
    // ---------------------------------------------------------------
    logic signed [SAMPLE_W-1:0]          win_val [MAX_KERNEL][MAX_KERNEL];
    logic [NUM_TAPS-1:0][DATA_WIDTH-1:0] prod_vec;

    for (genvar ki = 0; ki < MAX_KERNEL; ki++) begin : g_row
        for (genvar kj = 0; kj < MAX_KERNEL; kj++) begin : g_col
            c2dvs_cell_ctl_t            ctl;
            logic signed [SAMPLE_W-1:0] nb_val;
            logic signed [SAMPLE_W-1:0] weight_sel;

            assign ctl.shift_en = a_valid_reg;
            assign ctl.load_new = (KSIZE_W'(kj) == km1);

            if (kj == MAX_KERNEL - 1) begin : g_last
                assign nb_val = row_val[ki];
            end else begin : g_mid
                assign nb_val = win_val[ki][kj + 1];
            end

            // tap for this window place under the current kernel side
            always_comb begin
                weight_sel = '0;
                for (int kk = 1; kk <= MAX_KERNEL; kk++) begin
                    if ((k_eff == KSIZE_W'(kk)) && (ki < kk) && (kj < kk)) begin
                        weight_sel = taps_reg[TAP_W'((ki < kk && kj < kk) ?
                                                     ki * kk + kj : 0)];
                    end
                end
            end

            c2dvs_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .FRAC_BITS  (FRAC_BITS)
            ) u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .new_val   (row_val[ki]),
                .nb_val    (nb_val),
                .weight_in (weight_sel),
                .win_val   (win_val[ki][kj]),
                .prod      (prod_vec[ki * MAX_KERNEL + kj])
            );
        end
    end

    // ---------------------------------------------------------------
    // product sum
    // ---------------------------------------------------------------
    logic [DATA_WIDTH-1:0] sum_root;

    c2dvs_sum_tree #(
        .N     (NUM_TAPS),
        .WIDTH (DATA_WIDTH)
    ) u_sum_tree (
        .aclk   (aclk),
        .leaves (prod_vec),
        .root   (sum_root)
    );

    // result tags aligned with the tree root
    meta_t meta_reg [LEVELS + 2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS + 2; i++) begin
                meta_reg[i].valid <= 1'b0;
            end
        end else begin
            meta_reg[0].valid <= a_valid_reg && a_emit_reg;
            for (int i = 1; i < LEVELS + 2; i++) begin
                meta_reg[i].valid <= meta_reg[i - 1].valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        meta_reg[0].out_row <= POS_W'(DIM_W'(a_row_reg) - DIM_W'(km1));
        meta_reg[0].out_col <= POS_W'(DIM_W'(a_col_reg) - DIM_W'(km1));
        meta_reg[0].last    <= a_last_reg;
        for (int i = 1; i < LEVELS + 2; i++) begin
            meta_reg[i].out_row <= meta_reg[i - 1].out_row;
            meta_reg[i].out_col <= meta_reg[i - 1].out_col;
            meta_reg[i].last    <= meta_reg[i - 1].last;
        end
    end

    // bias add, wrapping at the data width
    logic [DATA_WIDTH-1:0] res;
    c2dvs_out_t            push_data;

    assign res  = sum_root + DATA_WIDTH'(bias_reg);
    assign push = meta_reg[LEVELS + 1].valid;

    assign push_data.conv_value = signed'(SAMPLE_W'(res));
    assign push_data.out_row    = meta_reg[LEVELS + 1].out_row;
    assign push_data.out_col    = meta_reg[LEVELS + 1].out_col;
    assign push_data.frame_last = meta_reg[LEVELS + 1].last;

    // ---------------------------------------------------------------
    // result queue
    // ---------------------------------------------------------------
    c2dvs_out_t      fifo_reg [FIFO_DEPTH];
    logic [FP_W-1:0] wr_ptr_reg;
    logic [FP_W-1:0] rd_ptr_reg;
    logic [FC_W-1:0] fifo_cnt_reg;

    assign m_valid = fifo_cnt_reg != '0;
    assign m_data  = fifo_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == FP_W'(FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + FP_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FP_W'(FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + FP_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + FC_W'(push) - FC_W'(pop);
        end
    end

    // results promised but not yet taken
    assign outstanding_next = outstanding_reg + FC_W'(pix_acc && pix_emit) - FC_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `ASSERT_ALWAYS(a_credit_bound, aclk, aresetn, outstanding_reg <= FC_W'(FIFO_DEPTH))
    `ASSERT_ALWAYS(a_queue_in_credit, aclk, aresetn, fifo_cnt_reg <= outstanding_reg)
    `ASSERT_IMPLIES(a_push_room, aclk, aresetn, push, (fifo_cnt_reg < FC_W'(FIFO_DEPTH)) || pop)
    `ASSERT_NEXT(a_pixel_staged, aclk, aresetn, pix_acc, a_valid_reg)

endmodule

// ===== tb/c2dvs_checker.sv =====
// checker for the streaming 2d convolution core: predicts results and compares them
`timescale 1ns / 100ps

module c2dvs_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  c2dvs_pkg::c2dvs_in_t          s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  c2dvs_pkg::c2dvs_out_t         m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c2dvs_pkg::APB_AW-1:0]  paddr,
    input  logic [c2dvs_pkg::APB_DW-1:0]  pwdata,
    input  logic [c2dvs_pkg::APB_DW-1:0]  prdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);
    import c2dvs_pkg::*;

    localparam int MAXK   = DEF_MAX_KERNEL;
    localparam int NTAPS  = MAXK * MAXK;
    localparam int NLINES = (MAXK > 1) ? MAXK - 1 : 1;
    localparam int NCOLS  = DEF_MAX_COLS;
    localparam int COLCAP = (NCOLS < 64) ? NCOLS : 64;
    localparam int FRAC   = DEF_FRAC_BITS;

    // shadow copy of the core state and registers
    logic signed [SAMPLE_W-1:0] taps     [0:NTAPS-1];
    logic signed [SAMPLE_W-1:0] line_mem [0:NLINES-1][0:NCOLS-1];
    logic signed [SAMPLE_W-1:0] win      [0:MAXK-1][0:MAXK-1];
    int                         pix_row;
    int                         pix_col;
    logic [KSIZE_W-1:0]         cfg_k;
    logic [DIM_W-1:0]           cfg_rows;
    logic [DIM_W-1:0]           cfg_cols;
    logic signed [SAMPLE_W-1:0] cfg_bias;

    // results still owed by the core, oldest first
    c2dvs_out_t conv_due [$];
    int         errs = 0;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic int eff_kernel();
        if (cfg_k == 0) return 1;
        if (cfg_k > MAXK) return MAXK;
        return cfg_k;
    endfunction

    function automatic int eff_rows();
        if (cfg_rows == 0) return 1;
        return (cfg_rows > ROW_LIMIT) ? ROW_LIMIT : cfg_rows;
    endfunction

    function automatic int eff_cols();
        if (cfg_cols == 0) return 1;
        return (cfg_cols > COLCAP) ? COLCAP : cfg_cols;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            errs++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // one accepted transaction: weight store or pixel through the window
    task automatic convolve_item(input c2dvs_in_t it);
        int k, nrows, ncols, r, c, ki, kj, src, pos;
        logic signed [SAMPLE_W-1:0] v;
        logic signed [31:0]         prod;
        logic [SAMPLE_W-1:0]        acc;
        c2dvs_out_t                 res;
        k = eff_kernel();
        nrows = eff_rows();
        ncols = eff_cols();
        if (it.cmd == CMD_WEIGHT) begin
            // indices past the tap store are dropped
            if (it.tap_index < NTAPS) taps[it.tap_index] = it.sample;
        end else begin
            if (pix_row >= nrows || pix_col >= ncols) begin
                pix_row = 0;
                pix_col = 0;
            end
            r = pix_row;
            c = pix_col;
            // shift the window left and load the new column
            for (ki = 0; ki < k; ki++) begin
                for (kj = 0; kj + 1 < k; kj++) win[ki][kj] = win[ki][kj+1];
                if (ki + 1 == k) begin
                    v = it.sample;
                end else if (r + ki >= k - 1) begin
                    src = r + ki - (k - 1);
                    v = line_mem[src % NLINES][c];
                end else begin
                    v = '0;
                end
                win[ki][k-1] = v;
            end
            line_mem[r % NLINES][c] = it.sample;
            // raster counters
            if (c + 1 >= ncols) begin
                pix_col = 0;
                pix_row = (r + 1 >= nrows) ? 0 : r + 1;
            end else begin
                pix_col = c + 1;
            end
            // full window: sum of floored products plus bias, wrapping
            if (r + 1 >= k && c + 1 >= k) begin
                acc = '0;
                for (ki = 0; ki < k; ki++) begin
                    for (kj = 0; kj < k; kj++) begin
                        prod = taps[ki*k+kj] * win[ki][kj];
                        prod = prod >>> FRAC;
                        acc = acc + prod[SAMPLE_W-1:0];
                    end
                end
                acc = acc + cfg_bias;
                res.conv_value = acc;
                pos = r - (k - 1);
                res.out_row = pos[POS_W-1:0];
                pos = c - (k - 1);
                res.out_col = pos[POS_W-1:0];
                res.frame_last = (r + 1 == nrows) && (c + 1 == ncols);
                conv_due.push_back(res);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        int i, j;
        c2dvs_out_t want;
        if (!aresetn) begin
            for (i = 0; i < NTAPS; i++) taps[i] = '0;
            for (i = 0; i < NLINES; i++)
                for (j = 0; j < NCOLS; j++) line_mem[i][j] = '0;
            for (i = 0; i < MAXK; i++)
                for (j = 0; j < MAXK; j++) win[i][j] = '0;
            pix_row = 0;
            pix_col = 0;
            cfg_k = RST_KERNEL_SIZE;
            cfg_rows = RST_IMAGE_ROWS;
            cfg_cols = RST_IMAGE_COLS;
            cfg_bias = RST_BIAS;
            conv_due.delete();
        end else begin
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                if (conv_due.size() == 0) begin
                    errs++;
                    $display("%0t unexpected result: expected none actual %0h", $time, m_data);
                end else begin
                    want = conv_due.pop_front();
                    compare_field("conv_value", want.conv_value, m_data.conv_value);
                    compare_field("out_row", want.out_row, m_data.out_row);
                    compare_field("out_col", want.out_col, m_data.out_col);
                    compare_field("frame_last", want.frame_last, m_data.frame_last);
                end
            end
            // register access phase
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_KERNEL_SIZE: begin
                            cfg_k = pwdata[KSIZE_W-1:0];
                            pix_row = 0;
                            pix_col = 0;
                        end
                        REG_IMAGE_ROWS: begin
                            cfg_rows = pwdata[DIM_W-1:0];
                            pix_row = 0;
                            pix_col = 0;
                        end
                        REG_IMAGE_COLS: begin
                            cfg_cols = pwdata[DIM_W-1:0];
                            pix_row = 0;
                            pix_col = 0;
                        end
                        REG_BIAS: cfg_bias = pwdata[SAMPLE_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[3:2])
                        REG_KERNEL_SIZE: compare_field("kernel_size readback", cfg_k,
                                                       prdata[KSIZE_W-1:0]);
                        REG_IMAGE_ROWS:  compare_field("image_rows readback", cfg_rows,
                                                       prdata[DIM_W-1:0]);
                        REG_IMAGE_COLS:  compare_field("image_cols readback", cfg_cols,
                                                       prdata[DIM_W-1:0]);
                        REG_BIAS:        compare_field("bias readback", {16'h0, cfg_bias},
                                                       {16'h0, prdata[SAMPLE_W-1:0]});
                        default: ;
                    endcase
                end
            end
            // input transaction
            if (s_valid && s_ready) convolve_item(s_data);
        end
        fail_count <= errs;
        pending <= conv_due.size();
    end

endmodule

// ===== tb/tb.sv =====
// testbench top for the streaming 2d convolution core: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb;
    import c2dvs_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 20;
    localparam int ITEMS_PER_MODE = 500;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    c2dvs_in_t           s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    c2dvs_out_t          m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int fail_count;
    int pending;
    int src_idle   = 0;
    int sink_idle  = 0;
    int hold_req_n = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int pix_sent   = 0;

    // 50 MHz clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    conv2d_valid_stream_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    c2dvs_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    // result side ready: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req_n != hold_seen) begin
            hold_seen <= hold_req_n;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    // sample values biased toward the extremes
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        logic [31:0] pick;
        pick = $urandom_range(0, 9);
        if (pick != 0) return $urandom;
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic c2dvs_in_t mk_item(input logic cmd, input logic [TAPIDX_W-1:0] idx,
                                          input logic [SAMPLE_W-1:0] smp);
        c2dvs_in_t it;
        it.cmd = cmd;
        it.tap_index = idx;
        it.sample = smp;
        return it;
    endfunction

    // offer one input transaction and wait for its acceptance
    task automatic send_item(input c2dvs_in_t it);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_pixel(input logic [SAMPLE_W-1:0] smp);
        send_item(mk_item(CMD_PIXEL, $urandom_range(0, 31), smp));
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every owed result is out and the pipeline is empty
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one geometry: program, read back, load taps, stream pixels
    task automatic run_phase(input logic [2:0] k, input logic [6:0] rows,
                             input logic [6:0] cols, input logic [15:0] bias,
                             input bit hold);
        int keff, reff, ceff, npix, i;
        settle();
        apb_access(1'b1, REG_KERNEL_SIZE, {29'h0, k});
        apb_access(1'b1, REG_IMAGE_ROWS, {25'h0, rows});
        apb_access(1'b1, REG_IMAGE_COLS, {25'h0, cols});
        apb_access(1'b1, REG_BIAS, {$urandom, bias});
        apb_access(1'b0, REG_KERNEL_SIZE, '0);
        apb_access(1'b0, REG_IMAGE_ROWS, '0);
        apb_access(1'b0, REG_IMAGE_COLS, '0);
        apb_access(1'b0, REG_BIAS, '0);
        keff = (k == 0) ? 1 : ((k > 5) ? 5 : k);
        reff = (rows == 0) ? 1 : ((rows > 64) ? 64 : rows);
        ceff = (cols == 0) ? 1 : ((cols > 64) ? 64 : cols);
        // every tap in use gets written before the first result
        for (i = 0; i < keff * keff; i++)
            send_item(mk_item(CMD_WEIGHT, i[TAPIDX_W-1:0], rand_sample()));
        send_item(mk_item(CMD_WEIGHT, $urandom_range(0, 31), rand_sample()));
        if (hold) begin
            npix = 64;
            hold_req_n <= hold_req_n + 1;
        end else begin
            npix = reff * ceff * $urandom_range(1, 2) + $urandom_range(0, 3);
            if (npix > 420) npix = 420;
        end
        for (i = 0; i < npix; i++) begin
            // occasional weight update in the middle of a frame
            if ($urandom_range(0, 99) < 4)
                send_item(mk_item(CMD_WEIGHT, $urandom_range(0, 31), rand_sample()));
            send_pixel(rand_sample());
            pix_sent++;
        end
    endtask

    initial begin : stimulus
        int mode, i, pick;
        logic [2:0]  rk;
        logic [6:0]  rr, rc;
        logic [15:0] rb;
        int fixed_k    [10] = '{1, 5, 0, 7, 6, 5, 1, 3, 5, 1};
        int fixed_rows [10] = '{1, 5, 0, 6, 3, 2, 127, 4, 6, 2};
        int fixed_cols [10] = '{1, 5, 0, 6, 3, 64, 1, 100, 64, 64};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin src_idle = 37; sink_idle = 70; end
                1: begin src_idle = 70; sink_idle = 37; end
                default: begin src_idle = 0; sink_idle = 0; end
            endcase

            if (mode == 0) begin
                // directed: 2x2 kernel over a 3x3 map, saturated bias
                apb_access(1'b1, REG_KERNEL_SIZE, 32'd2);
                apb_access(1'b1, REG_IMAGE_ROWS, 32'd3);
                apb_access(1'b1, REG_IMAGE_COLS, 32'd3);
                apb_access(1'b1, REG_BIAS, 32'h0000_7FFF);
                send_item(mk_item(CMD_WEIGHT, 5'd0, 16'h8000));
                send_item(mk_item(CMD_WEIGHT, 5'd1, 16'h7FFF));
                send_item(mk_item(CMD_WEIGHT, 5'd2, 16'h0100));
                send_item(mk_item(CMD_WEIGHT, 5'd3, 16'hFFFF));
                // out-of-range index is dropped, unused index is kept
                send_item(mk_item(CMD_WEIGHT, 5'd31, 16'h1234));
                send_item(mk_item(CMD_WEIGHT, 5'd24, 16'h5555));
                send_pixel(16'h8000);
                send_pixel(16'h7FFF);
                send_pixel(16'h0000);
                send_pixel(16'hFFFF);
                send_pixel(16'h0100);
                // weight change mid-frame takes effect on the next result
                send_item(mk_item(CMD_WEIGHT, 5'd0, 16'h0080));
                send_pixel(16'h8000);
                send_pixel(16'h7FFF);
                send_pixel(16'h0001);
                send_pixel(16'hFF00);
                // frame wraps back to the first position
                send_pixel(16'h7FFF);
                send_pixel(16'h8000);
                send_pixel(16'h7FFF);

                // corner geometries: out-of-range sizes, kernel larger than map
                for (i = 0; i < 10; i++)
                    run_phase(fixed_k[i], fixed_rows[i], fixed_cols[i],
                              (i % 2 == 0) ? 16'h8000 : 16'h7FFF, 1'b0);
            end

            // long result stall while pixels keep coming
            run_phase(3'd1, 7'd8, 7'd8, $urandom, 1'b1);

            pix_sent = 0;
            while (pix_sent < ITEMS_PER_MODE) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    pick = $urandom_range(0, 2);
                    rk = (pick == 0) ? 3'd0 : 3'(5 + pick);
                end else begin
                    rk = $urandom_range(1, 5);
                end
                if ($urandom_range(0, 9) == 0) begin
                    rr = $urandom_range(60, 127);
                    rc = $urandom_range(0, 2);
                end else begin
                    rr = $urandom_range(0, 9);
                    rc = $urandom_range(0, 9);
                end
                rb = rand_sample();
                run_phase(rk, rr, rc, rb, 1'b0);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("conv2d_valid_stream_core regression: pass");
        end else begin
            $display("conv2d_valid_stream_core regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("conv2d_valid_stream_core regression: fail");
        $finish;
    end

endmodule
